@@ rtl/core/smsp_pkg.sv @@
// Package for the straight move speed profile block.
// Holds widths, light and kind codes, beat and bundle types and helpers.
// No dependencies.
package smsp_pkg;

    // value widths (signed Q16.16 speeds, unsigned lengths and steps)
    localparam int VW = 32;
    localparam int LW = VW - 1;
    localparam int RW = VW + 1;
    localparam int XW = VW + 2;
    localparam int PW = 2 * VW;
    localparam int QW = 2 * LW;

    // item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // light codes
    localparam logic [1:0] LIGHT_STRAIGHT = 2'd0;
    localparam logic [1:0] LIGHT_REVERSE  = 2'd1;
    localparam logic [1:0] LIGHT_ERROR    = 2'd2;
    localparam logic [1:0] LIGHT_STANDBY  = 2'd3;

    // map codes
    localparam logic MAP_WALK = 1'b0;
    localparam logic MAP_WORK = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic signed [VW-1:0] cruise_speed;
        logic signed [VW-1:0] final_speed;
        logic [LW-1:0]        travel_length;
        logic [LW-1:0]        speed_step;
        logic                 waypoint_flag;
        logic                 safety_stop;
    } item_t;

    typedef struct packed {
        logic signed [VW-1:0] speed_command;
        logic                 speed_valid;
        logic [1:0]           light_code;
        logic                 map_code;
        logic                 move_done;
        logic                 last;
    } beat_t;

    // all result beats of one item; two marks a second beat
    typedef struct packed {
        beat_t beat0;
        beat_t beat1;
        logic  two;
    } bundle_t;

    // magnitude of a signed value; the most negative value maps to 2^(VW-1)
    function automatic logic [VW-1:0] mag(input logic signed [VW-1:0] v);
        logic [VW-1:0] r;
        r = v[VW-1] ? VW'(-v) : VW'(v);
        return r;
    endfunction

endpackage

@@ rtl/core/smsp_if.sv @@
// Handshake interfaces for the item and result channels.
// Depends on smsp_pkg.
interface smsp_item_if;
    import smsp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic signed [VW-1:0] cruise_speed;
    logic signed [VW-1:0] final_speed;
    logic [LW-1:0]        travel_length;
    logic [LW-1:0]        speed_step;
    logic                 waypoint_flag;
    logic                 safety_stop;

    modport source (
        output valid, kind, cruise_speed, final_speed, travel_length,
               speed_step, waypoint_flag, safety_stop,
        input  ready
    );
    modport sink (
        input  valid, kind, cruise_speed, final_speed, travel_length,
               speed_step, waypoint_flag, safety_stop,
        output ready
    );
endinterface

interface smsp_result_if;
    import smsp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic signed [VW-1:0] speed_command;
    logic                 speed_valid;
    logic [1:0]           light_code;
    logic                 map_code;
    logic                 move_done;
    logic                 last;

    modport source (
        output valid, speed_command, speed_valid, light_code, map_code,
               move_done, last,
        input  ready
    );
    modport sink (
        input  valid, speed_command, speed_valid, light_code, map_code,
               move_done, last,
        output ready
    );
endinterface

@@ rtl/core/straight_move_speed_profile_top.sv @@
// Straight move speed profile. Throughput one item per cycle while the result queue is
// not full; a move-ending item adds one more result beat. Rate is set by the state
// update in smsp_core (multiply into state).
// Reset clears the move state, squared-speed cache, input valid flag and result queue.
// Depends on smsp_pkg, smsp_if, smsp_in_stage, smsp_core, smsp_out_stage.
module straight_move_speed_profile_top (
    input  logic          clk,
    input  logic          rst_n,
    smsp_item_if.sink     item,
    smsp_result_if.source result
);
    import smsp_pkg::*;

    item_t   item_q;
    logic    item_vld;
    logic    take;
    logic    push;
    logic    full;
    bundle_t bundle;

    smsp_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .take     (take),
        .item_q   (item_q),
        .item_vld (item_vld)
    );

    smsp_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_q   (item_q),
        .item_vld (item_vld),
        .full     (full),
        .take     (take),
        .push     (push),
        .bundle   (bundle)
    );

    smsp_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .bundle (bundle),
        .full   (full),
        .result (result)
    );

endmodule

@@ rtl/core/smsp_in_stage.sv @@
// Input register of the speed profile block.
// Depends on smsp_pkg and smsp_item_if.
module smsp_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    smsp_item_if.sink       item,
    input  logic            take,
    output smsp_pkg::item_t item_q,
    output logic            item_vld
);
    import smsp_pkg::*;

    item_t item_reg;
    item_t item_next;
    logic  vld_reg;
    logic  vld_next;
    logic  accept;

    // register empties or drains this cycle
    assign item.ready = !vld_reg || take;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        item_next = item_reg;
        vld_next  = vld_reg;
        if (accept)
        begin
            item_next.kind          = item.kind;
            item_next.cruise_speed  = item.cruise_speed;
            item_next.final_speed   = item.final_speed;
            item_next.travel_length = item.travel_length;
            item_next.speed_step    = item.speed_step;
            item_next.waypoint_flag = item.waypoint_flag;
            item_next.safety_stop   = item.safety_stop;
            vld_next                = 1'b1;
        end
        else if (take)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_q   = item_reg;
    assign item_vld = vld_reg;

endmodule

@@ rtl/core/smsp_core.sv @@
// Move state and per-item datapath of the speed profile block.
// Keeps squared speed and length*step products so the braking test is a compare.
// Depends on smsp_pkg.
module smsp_core (
    input  logic              clk,
    input  logic              rst_n,
    input  smsp_pkg::item_t   item_q,
    input  logic              item_vld,
    input  logic              full,
    output logic              take,
    output logic              push,
    output smsp_pkg::bundle_t bundle
);
    import smsp_pkg::*;

    // move state
    logic signed [VW-1:0] cur_reg, cur_next;
    logic signed [RW-1:0] rem_reg, rem_next;
    logic signed [VW-1:0] tgt_reg, tgt_next;
    logic signed [VW-1:0] fin_reg, fin_next;
    logic [LW-1:0]        step_reg, step_next;
    logic                 active_reg, active_next;
    logic                 sub_reg, sub_next;
    logic                 wp_reg, wp_next;
    // cached products
    logic [PW-1:0]        cur_sq_reg, cur_sq_next;
    logic [PW-1:0]        fin_sq_reg, fin_sq_next;
    logic [QW-1:0]        rem_step_reg, rem_step_next;

    logic                 is_start;
    logic [PW:0]          brake_rhs;
    logic                 brake;
    logic signed [VW-1:0] tgt_eff;
    logic [VW-1:0]        mag_cur;
    logic                 kill;
    logic signed [VW-1:0] c1;
    logic signed [RW-1:0] rem1;
    logic signed [XW-1:0] c1x, tx, sx, upx, dnx, c2x;
    logic signed [VW-1:0] c2;
    logic [VW-1:0]        mag_c2;
    logic signed [RW-1:0] rem2;
    logic signed [RW-1:0] rem_end;
    logic [VW-1:0]        mula_op;
    logic [PW-1:0]        mula;
    logic [LW-1:0]        mulb_a, mulb_b;
    logic [QW-1:0]        mulb;
    beat_t                fin_beat;
    beat_t                b0;
    logic                 has_beat;
    logic                 finish;

    assign take     = item_vld && !full;
    assign is_start = (item_q.kind == KIND_START);

    // braking test: cur^2 >= fin^2 + 2*rem*step
    assign brake_rhs = {1'b0, fin_sq_reg} + (PW+1)'({rem_step_reg, 1'b0});
    assign brake     = {1'b0, cur_sq_reg} >= brake_rhs;
    assign tgt_eff   = brake ? fin_reg : tgt_reg;

    // stop rules
    assign mag_cur = mag(cur_reg);
    assign kill    = ($signed({rem_reg[RW-1], rem_reg}) < $signed({2'b00, mag_cur}))
                  || ((tgt_eff == '0) && (mag_cur < {1'b0, step_reg}));
    assign c1      = kill ? '0 : cur_reg;
    assign rem1    = kill ? '0 : rem_reg;

    // ramp one step toward the target, clamped
    assign c1x = {{2{c1[VW-1]}}, c1};
    assign tx  = {{2{tgt_eff[VW-1]}}, tgt_eff};
    assign sx  = {3'b000, step_reg};
    assign upx = c1x + sx;
    assign dnx = c1x - sx;

    always_comb
    begin
        if (c1x < tx)
        begin
            c2x = (upx > tx) ? tx : upx;
        end
        else if (c1x > tx)
        begin
            c2x = (dnx < tx) ? tx : dnx;
        end
        else
        begin
            c2x = c1x;
        end
    end

    assign c2     = c2x[VW-1:0];
    assign mag_c2 = mag(c2);
    assign rem2   = sub_reg ? (rem1 - $signed({1'b0, mag_c2})) : rem1;

    // shared multipliers: squared speed, and length times step
    assign mula_op = is_start ? mag(item_q.final_speed) : mag_c2;
    assign mula    = PW'(mula_op) * PW'(mula_op);
    assign mulb_a  = is_start ? item_q.travel_length : rem2[LW-1:0];
    assign mulb_b  = is_start ? item_q.speed_step : step_reg;
    assign mulb    = QW'(mulb_a) * QW'(mulb_b);

    // final beat of a move
    always_comb
    begin
        fin_beat.speed_command = is_start ? item_q.final_speed : fin_reg;
        fin_beat.speed_valid   = 1'b1;
        fin_beat.light_code    = (is_start ? item_q.waypoint_flag : wp_reg)
                                 ? LIGHT_STANDBY : LIGHT_STRAIGHT;
        fin_beat.map_code      = (is_start ? item_q.waypoint_flag : wp_reg)
                                 ? MAP_WORK : MAP_WALK;
        fin_beat.move_done     = 1'b1;
        fin_beat.last          = 1'b1;
    end

    // next state and result bundle
    always_comb
    begin
        cur_next      = cur_reg;
        rem_next      = rem_reg;
        tgt_next      = tgt_reg;
        fin_next      = fin_reg;
        step_next     = step_reg;
        active_next   = active_reg;
        sub_next      = sub_reg;
        wp_next       = wp_reg;
        cur_sq_next   = cur_sq_reg;
        fin_sq_next   = fin_sq_reg;
        rem_step_next = rem_step_reg;
        b0            = '0;
        has_beat      = 1'b0;
        rem_end       = rem_reg;
        finish        = 1'b0;

        if (is_start)
        begin
            tgt_next      = item_q.cruise_speed;
            fin_next      = item_q.final_speed;
            rem_next      = RW'(item_q.travel_length);
            step_next     = item_q.speed_step;
            wp_next       = item_q.waypoint_flag;
            sub_next      = 1'b0;
            active_next   = 1'b1;
            fin_sq_next   = mula;
            rem_step_next = mulb;
            has_beat      = 1'b1;
            b0.light_code = item_q.cruise_speed[VW-1] ? LIGHT_REVERSE : LIGHT_STRAIGHT;
            b0.map_code   = MAP_WALK;
            finish        = (item_q.travel_length == '0);
            if (finish)
            begin
                cur_sq_next = mula;
            end
        end
        else if (active_reg)
        begin
            has_beat       = 1'b1;
            tgt_next       = tgt_eff;
            b0.speed_valid = 1'b1;
            if (!item_q.safety_stop)
            begin
                cur_next         = c2;
                rem_next         = rem2;
                rem_end          = rem2;
                sub_next         = 1'b1;
                cur_sq_next      = mula;
                rem_step_next    = mulb;
                b0.speed_command = c2;
                b0.light_code    = LIGHT_STRAIGHT;
            end
            else
            begin
                cur_next         = '0;
                sub_next         = 1'b0;
                cur_sq_next      = '0;
                b0.speed_command = '0;
                b0.light_code    = LIGHT_ERROR;
            end
            finish = (rem_end <= 0);
            if (finish)
            begin
                cur_sq_next = fin_sq_reg;
            end
        end

        if (finish)
        begin
            cur_next    = is_start ? item_q.final_speed : fin_reg;
            active_next = 1'b0;
            sub_next    = 1'b0;
        end
        b0.last = !finish;

        bundle.beat0 = b0;
        bundle.beat1 = fin_beat;
        bundle.two   = finish;
        push         = take && has_beat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg      <= '0;
            rem_reg      <= '0;
            tgt_reg      <= '0;
            fin_reg      <= '0;
            step_reg     <= '0;
            active_reg   <= 1'b0;
            sub_reg      <= 1'b0;
            wp_reg       <= 1'b0;
            cur_sq_reg   <= '0;
            fin_sq_reg   <= '0;
            rem_step_reg <= '0;
        end
        else if (take)
        begin
            cur_reg      <= cur_next;
            rem_reg      <= rem_next;
            tgt_reg      <= tgt_next;
            fin_reg      <= fin_next;
            step_reg     <= step_next;
            active_reg   <= active_next;
            sub_reg      <= sub_next;
            wp_reg       <= wp_next;
            cur_sq_reg   <= cur_sq_next;
            fin_sq_reg   <= fin_sq_next;
            rem_step_reg <= rem_step_next;
        end
    end

endmodule

@@ rtl/core/smsp_out_stage.sv @@
// Result queue of the speed profile block: two bundles, sent one beat at a time.
// Depends on smsp_pkg and smsp_result_if.
module smsp_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  smsp_pkg::bundle_t bundle,
    output logic              full,
    smsp_result_if.source     result
);
    import smsp_pkg::*;

    bundle_t    mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       sel_reg, sel_next;
    bundle_t    head;
    beat_t      beat;
    logic       pop_beat;
    logic       pop_bundle;

    assign head = mem_reg[rd_ptr_reg];
    assign beat = sel_reg ? head.beat1 : head.beat0;

    // result channel
    assign result.valid         = (cnt_reg != 2'd0);
    assign result.speed_command = beat.speed_command;
    assign result.speed_valid   = beat.speed_valid;
    assign result.light_code    = beat.light_code;
    assign result.map_code      = beat.map_code;
    assign result.move_done     = beat.move_done;
    assign result.last          = beat.last;

    assign full       = (cnt_reg == 2'd2);
    assign pop_beat   = result.valid && result.ready;
    assign pop_bundle = pop_beat && (sel_reg || !head.two);

    // pointers and beat select
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_bundle ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop_bundle);
        sel_next    = sel_reg;
        if (pop_bundle)
        begin
            sel_next = 1'b0;
        end
        else if (pop_beat)
        begin
            sel_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            sel_reg    <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            sel_reg    <= sel_next;
        end
    end

    // bundle storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= bundle;
        end
    end

endmodule

@@ rtl/core/smsp_checker.sv @@
// Port-level checks on the result channel of the speed profile block.
// Depends on smsp_pkg; bound to straight_move_speed_profile_top.
module smsp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic signed [smsp_pkg::VW-1:0] res_speed,
    input logic                          res_speed_valid,
    input logic [1:0]                    res_light,
    input logic                          res_map,
    input logic                          res_done,
    input logic                          res_last
);
    import smsp_pkg::*;

    // a stalled beat stays valid and holds its speed and done flag
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_speed) && $stable(res_done))
        else $error("result beat changed while stalled");

    // the move-ending beat closes its item and carries a command
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_done |-> res_last && res_speed_valid)
        else $error("move end beat not last or not a command");

    // emergency beat commands zero speed
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_light == LIGHT_ERROR |-> res_speed == '0 && res_speed_valid
            && !res_done)
        else $error("error light with nonzero speed");

    // the start answer carries no command
    a_start_beat: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_speed_valid |-> res_speed == '0 && res_map == MAP_WALK
            && (res_light == LIGHT_STRAIGHT || res_light == LIGHT_REVERSE))
        else $error("malformed start beat");

endmodule

bind straight_move_speed_profile_top smsp_checker u_smsp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .res_speed       (result.speed_command),
    .res_speed_valid (result.speed_valid),
    .res_light       (result.light_code),
    .res_map         (result.map_code),
    .res_done        (result.move_done),
    .res_last        (result.last)
);

@@ bench/straight_move_speed_profile_top_tb.sv @@
// Self-checking bench for straight_move_speed_profile_top: drives start and tick beats,
// predicts every result beat of the speed profile and compares it field by field.
// Depends on smsp_pkg, smsp_if and the straight_move_speed_profile_top RTL.
module straight_move_speed_profile_top_tb;
    import smsp_pkg::*;

    localparam int LIMIT        = 300000;
    localparam int TAIL         = 16;
    localparam int RANDOM_ITEMS = 330;

    localparam logic signed [VW-1:0] SPEED_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] SPEED_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic [LW-1:0]        LEN_MAX   = '1;
    localparam beat_t                NO_BEAT   = '0;

    // one row of the directed table; hand rows carry their results typed in
    typedef struct {
        item_t it;
        bit    hand;
        int    n;
        beat_t b0;
        beat_t b1;
    } row_t;

    logic clk;
    logic rst_n;

    smsp_item_if   item_ch ();
    smsp_result_if result_ch ();

    straight_move_speed_profile_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // predicted move state
    logic signed [VW-1:0] spd_now;
    logic signed [RW-1:0] dist_left;
    logic signed [VW-1:0] tgt_spd;
    logic signed [VW-1:0] end_spd;
    logic [LW-1:0]        ramp_step;
    bit                   moving;
    bit                   dist_count_on;
    bit                   end_at_station;

    beat_t due_commands[$];
    row_t  plan[$];
    int    errors = 0;
    int    cycles = 0;
    int    stall_left = 0;
    int    served_items = 0;
    bit    steady = 0;

    always #10 clk = ~clk;

    // mostly short gaps, a few long ones; none during a steady stretch
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic longint speed_mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // advance the predicted profile by one accepted item; returns the beat count
    function automatic int step_profile(input item_t it, output beat_t first,
                                        output beat_t second);
        beat_t       got[2];
        int          n;
        longint      cur;
        longint      dl;
        longint      stp;
        longint      tgt;
        logic [65:0] lhs;
        logic [65:0] rhs;
        got[0] = '0;
        got[1] = '0;
        first  = '0;
        second = '0;
        n      = 0;
        if (it.kind == KIND_START) begin
            tgt_spd        = it.cruise_speed;
            end_spd        = it.final_speed;
            dist_left      = RW'(it.travel_length);
            ramp_step      = it.speed_step;
            end_at_station = it.waypoint_flag;
            dist_count_on  = 1'b0;
            moving         = 1'b1;
            got[0] = '{'0, 1'b0, (it.cruise_speed < 0) ? LIGHT_REVERSE : LIGHT_STRAIGHT,
                       MAP_WALK, 1'b0, 1'b0};
            n  = 1;
            dl = dist_left;
        end
        else begin
            if (!moving)
                return 0;
            cur = spd_now;
            dl  = dist_left;
            stp = ramp_step;
            // braking due: cur^2 - end^2 >= 2 * dist * step, on exact products
            lhs = 66'(speed_mag(cur)) * 66'(speed_mag(cur));
            rhs = 66'(speed_mag(end_spd)) * 66'(speed_mag(end_spd))
                + 2 * (66'(dl) * 66'(stp));
            if (lhs >= rhs)
                tgt_spd = end_spd;
            tgt = tgt_spd;
            if (!it.safety_stop) begin
                // stop rules: overshooting the distance, or too slow to reach a zero target
                if (dl < speed_mag(cur)) begin
                    dl  = 0;
                    cur = 0;
                end
                if (tgt == 0 && speed_mag(cur) < stp) begin
                    dl  = 0;
                    cur = 0;
                end
                // ramp one step, clamped at the target
                if (cur < tgt) begin
                    cur += stp;
                    if (cur > tgt)
                        cur = tgt;
                end
                else if (cur > tgt) begin
                    cur -= stp;
                    if (cur < tgt)
                        cur = tgt;
                end
                if (dist_count_on)
                    dl -= speed_mag(cur);
                spd_now       = VW'(cur);
                dist_count_on = 1'b1;
                got[0] = '{VW'(cur), 1'b1, LIGHT_STRAIGHT, MAP_WALK, 1'b0, 1'b0};
            end
            else begin
                spd_now       = '0;
                dist_count_on = 1'b0;
                got[0] = '{'0, 1'b1, LIGHT_ERROR, MAP_WALK, 1'b0, 1'b0};
            end
            n         = 1;
            dist_left = RW'(dl);
        end
        // distance used up: the move ends on the end speed
        if (dl <= 0) begin
            got[n] = '{end_spd, 1'b1, end_at_station ? LIGHT_STANDBY : LIGHT_STRAIGHT,
                       end_at_station ? MAP_WORK : MAP_WALK, 1'b1, 1'b0};
            n++;
            spd_now       = end_spd;
            moving        = 1'b0;
            dist_count_on = 1'b0;
        end
        got[n-1].last = 1'b1;
        first  = got[0];
        second = got[1];
        return n;
    endfunction

    function automatic item_t start_item(input logic signed [VW-1:0] cru,
                                         input logic signed [VW-1:0] fin,
                                         input logic [LW-1:0] len,
                                         input logic [LW-1:0] stp, input bit wp);
        item_t it;
        it = '{KIND_START, cru, fin, len, stp, wp, 1'($urandom)};
        return it;
    endfunction

    // tick beats carry random content in the fields the block ignores
    function automatic item_t tick_item(input bit stop);
        item_t it;
        it = '{KIND_TICK, VW'($urandom), VW'($urandom), LW'($urandom), LW'($urandom),
               1'($urandom), stop};
        return it;
    endfunction

    function automatic row_t on_model(input item_t it);
        row_t row;
        row = '{it, 1'b0, 0, NO_BEAT, NO_BEAT};
        return row;
    endfunction

    function automatic row_t by_hand(input item_t it, input int n, input beat_t b0,
                                     input beat_t b1);
        row_t row;
        row = '{it, 1'b1, n, b0, b1};
        return row;
    endfunction

    task automatic queue_beats(input int n, input beat_t b0, input beat_t b1);
        if (n > 0)
            due_commands.push_back(b0);
        if (n > 1)
            due_commands.push_back(b1);
    endtask

    // offer one item beat after a random gap and predict it once accepted
    task automatic send_item(input item_t it, output int n, output beat_t b0,
                             output beat_t b1);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.kind          <= it.kind;
        item_ch.cruise_speed  <= it.cruise_speed;
        item_ch.final_speed   <= it.final_speed;
        item_ch.travel_length <= it.travel_length;
        item_ch.speed_step    <= it.speed_step;
        item_ch.waypoint_flag <= it.waypoint_flag;
        item_ch.safety_stop   <= it.safety_stop;
        do
            @(posedge clk);
        while (!item_ch.ready);
        n = step_profile(it, b0, b1);
    endtask

    task automatic feed(input item_t it);
        int    n;
        beat_t b0;
        beat_t b1;
        send_item(it, n, b0, b1);
        queue_beats(n, b0, b1);
        served_items++;
    endtask

    // drop valid and hold off until every predicted beat has come out
    task automatic drain_channel();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        wait (due_commands.size() == 0);
    endtask

    // result side: random back-pressure
    always @(negedge clk)
    begin
        if (stall_left == 0)
            stall_left = pick_gap();
        if (stall_left > 0) begin
            result_ch.ready <= 1'b0;
            stall_left--;
        end
        else
            result_ch.ready <= 1'b1;
    end

    // compare each result beat with the oldest prediction
    always @(posedge clk)
    begin : check_results
        beat_t want;
        beat_t got;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            got = '{result_ch.speed_command, result_ch.speed_valid, result_ch.light_code,
                    result_ch.map_code, result_ch.move_done, result_ch.last};
            if (due_commands.size() == 0) begin
                $error("result beat with nothing expected: speed_command %0d",
                       got.speed_command);
                errors++;
            end
            else begin
                want = due_commands.pop_front();
                if (got.speed_command !== want.speed_command) begin
                    $error("speed_command: expected %0d, got %0d",
                           want.speed_command, got.speed_command);
                    errors++;
                end
                if (got.speed_valid !== want.speed_valid) begin
                    $error("speed_valid: expected %0d, got %0d",
                           want.speed_valid, got.speed_valid);
                    errors++;
                end
                if (got.light_code !== want.light_code) begin
                    $error("light_code: expected %0d, got %0d",
                           want.light_code, got.light_code);
                    errors++;
                end
                if (got.map_code !== want.map_code) begin
                    $error("map_code: expected %0d, got %0d", want.map_code, got.map_code);
                    errors++;
                end
                if (got.move_done !== want.move_done) begin
                    $error("move_done: expected %0d, got %0d", want.move_done, got.move_done);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("[straight_move_speed_profile_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        int                   n;
        int                   r;
        int                   moves;
        int                   stp;
        int                   cmag;
        int                   fmag;
        beat_t                b0;
        beat_t                b1;
        item_t                it;
        logic signed [VW-1:0] cru;
        logic signed [VW-1:0] fin;
        logic [LW-1:0]        len;

        clk                   = 1'b0;
        rst_n                 = 1'b0;
        item_ch.valid         = 1'b0;
        item_ch.kind          = KIND_START;
        item_ch.cruise_speed  = '0;
        item_ch.final_speed   = '0;
        item_ch.travel_length = '0;
        item_ch.speed_step    = '0;
        item_ch.waypoint_flag = 1'b0;
        item_ch.safety_stop   = 1'b0;
        result_ch.ready       = 1'b0;
        spd_now               = '0;
        dist_left             = '0;
        tgt_spd               = '0;
        end_spd               = '0;
        ramp_step             = '0;
        moving                = 1'b0;
        dist_count_on         = 1'b0;
        end_at_station        = 1'b0;

        // directed table
        // tick with no move running is dropped
        plan.push_back(by_hand(tick_item(1'b0), 0, NO_BEAT, NO_BEAT));
        // zero distance ends the move at once, with and without a waypoint
        plan.push_back(by_hand(start_item(SPEED_MAX, '0, '0, '0, 1'b1), 2,
            '{'0, 1'b0, LIGHT_STRAIGHT, MAP_WALK, 1'b0, 1'b0},
            '{'0, 1'b1, LIGHT_STANDBY, MAP_WORK, 1'b1, 1'b1}));
        plan.push_back(by_hand(start_item(SPEED_MIN, -32'sd5, '0, LEN_MAX, 1'b0), 2,
            '{'0, 1'b0, LIGHT_REVERSE, MAP_WALK, 1'b0, 1'b0},
            '{-32'sd5, 1'b1, LIGHT_STRAIGHT, MAP_WALK, 1'b1, 1'b1}));
        plan.push_back(by_hand(tick_item(1'b1), 0, NO_BEAT, NO_BEAT));
        // extreme distance and step, speed carried over from the last move
        plan.push_back(by_hand(start_item(SPEED_MAX, '0, LEN_MAX, LEN_MAX, 1'b1), 1,
            '{'0, 1'b0, LIGHT_STRAIGHT, MAP_WALK, 1'b0, 1'b1}, NO_BEAT));
        plan.push_back(on_model(tick_item(1'b0)));
        plan.push_back(by_hand(tick_item(1'b1), 1,
            '{'0, 1'b1, LIGHT_ERROR, MAP_WALK, 1'b0, 1'b1}, NO_BEAT));
        plan.push_back(on_model(tick_item(1'b0)));
        plan.push_back(on_model(tick_item(1'b0)));
        // reverse move with an emergency stop, then braking into the end speed
        plan.push_back(by_hand(start_item(-32'sh30000, '0, 31'h100000, 31'h10000, 1'b0),
            1, '{'0, 1'b0, LIGHT_REVERSE, MAP_WALK, 1'b0, 1'b1}, NO_BEAT));
        repeat (3) plan.push_back(on_model(tick_item(1'b0)));
        plan.push_back(by_hand(tick_item(1'b1), 1,
            '{'0, 1'b1, LIGHT_ERROR, MAP_WALK, 1'b0, 1'b1}, NO_BEAT));
        repeat (6) plan.push_back(on_model(tick_item(1'b0)));
        // a start while a move is running replaces it
        plan.push_back(by_hand(start_item(32'sh20000, -32'sh8000, 31'h80000, 31'h4000, 1'b1),
            1, '{'0, 1'b0, LIGHT_STRAIGHT, MAP_WALK, 1'b0, 1'b1}, NO_BEAT));
        plan.push_back(on_model(tick_item(1'b0)));
        plan.push_back(by_hand(start_item(-32'sh10000, 32'sh10000, 31'h40000, 31'h8000, 1'b0),
            1, '{'0, 1'b0, LIGHT_REVERSE, MAP_WALK, 1'b0, 1'b1}, NO_BEAT));
        repeat (2) plan.push_back(on_model(tick_item(1'b0)));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i]) begin
            send_item(plan[i].it, n, b0, b1);
            if (plan[i].hand)
                queue_beats(plan[i].n, plan[i].b0, plan[i].b1);
            else
                queue_beats(n, b0, b1);
        end
        drain_channel();

        // random moves: mostly well-formed, some extreme starts and stray ticks
        moves = 0;
        while (served_items < RANDOM_ITEMS) begin
            steady = ((moves % 14) == 6);
            if ($urandom_range(0, 19) == 0)
                drain_channel();
            r = $urandom_range(0, 99);
            if (r < 8) begin
                repeat ($urandom_range(1, 3)) feed(tick_item($urandom_range(0, 9) == 0));
            end
            else begin
                if (r < 20) begin
                    it = start_item(VW'($urandom), VW'($urandom), LW'($urandom),
                                    LW'($urandom), 1'($urandom));
                end
                else begin
                    stp = $urandom_range(1, 32'h40000);
                    if ($urandom_range(0, 19) == 0)
                        stp = 0;
                    cmag = stp * $urandom_range(1, 8) + $urandom_range(0, stp);
                    cru  = $urandom_range(0, 1) ? VW'(-cmag) : VW'(cmag);
                    fmag = $urandom_range(0, cmag);
                    fin  = $urandom_range(0, 1) ? VW'(-fmag) : VW'(fmag);
                    if ($urandom_range(0, 9) < 4)
                        fin = '0;
                    len = LW'(cmag * $urandom_range(0, 20) + $urandom_range(0, 32'hFFFF));
                    if ($urandom_range(0, 19) == 0)
                        len = '0;
                    it = start_item(cru, fin, len, LW'(stp), 1'($urandom));
                end
                feed(it);
                repeat ($urandom_range(1, 30)) feed(tick_item($urandom_range(0, 99) < 6));
            end
            moves++;
        end
        steady = 1'b0;

        // let the last beats out, then watch a little longer for strays
        drain_channel();
        repeat (TAIL) @(posedge clk);
        if (errors == 0)
            $display("[straight_move_speed_profile_top] OK");
        else
            $display("[straight_move_speed_profile_top] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/smsp_pkg.sv
rtl/core/smsp_if.sv
rtl/core/smsp_in_stage.sv
rtl/core/smsp_core.sv
rtl/core/smsp_out_stage.sv
rtl/core/straight_move_speed_profile_top.sv
rtl/core/smsp_checker.sv
bench/straight_move_speed_profile_top_tb.sv
